FILE: rtl/mpqm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqm_pkg
// Shared constants for the message pool queue manager.
// ----------------------------------------------------------------------------
package mpqm_pkg;

  // Default sizes
  localparam int NODES_DEF      = 64;
  localparam int BODY_WIDTH_DEF = 32;

  // Compare width for slot, queue and base values (NODES stays below 256)
  localparam int CMP_W = 9;

  // Fixed roots
  localparam logic [CMP_W-1:0] MAILBOX_ROOTS = 9'd2;
  localparam logic [CMP_W-1:0] FREE_ROOT     = 9'd0;
  localparam logic [CMP_W-1:0] BUSY_ROOT     = 9'd1;

  // Operation codes
  localparam logic [2:0] FUNC_INIT    = 3'd0;
  localparam logic [2:0] FUNC_ALLOC   = 3'd1;
  localparam logic [2:0] FUNC_POST    = 3'd2;
  localparam logic [2:0] FUNC_RECEIVE = 3'd3;
  localparam logic [2:0] FUNC_FREE    = 3'd4;
  localparam logic [2:0] FUNC_READ    = 3'd5;

  // Register indexes
  localparam logic REG_NUM_ROOTS = 1'b0;
  localparam logic REG_MODE      = 1'b1;

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_TAKE  = 4'd1;
  localparam logic [3:0] ST_TAKE2 = 4'd2;
  localparam logic [3:0] ST_UNL   = 4'd3;
  localparam logic [3:0] ST_UL1   = 4'd4;
  localparam logic [3:0] ST_UL2   = 4'd5;
  localparam logic [3:0] ST_AP1   = 4'd6;
  localparam logic [3:0] ST_AP2   = 4'd7;
  localparam logic [3:0] ST_SWEEP = 4'd8;
  localparam logic [3:0] ST_RDP   = 4'd9;

endpackage

FILE: rtl/mpqm_link_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqm_link_ram
// Next and previous link memories: one write port each, one shared
// registered read address.
// ----------------------------------------------------------------------------
module mpqm_link_ram #(
  parameter int NODES = mpqm_pkg::NODES_DEF,
  parameter int IDXW  = $clog2(NODES)
) (
  input  logic            clk,
  input  logic            nw_en,
  input  logic [IDXW-1:0] nw_addr,
  input  logic [IDXW-1:0] nw_data,
  input  logic            pw_en,
  input  logic [IDXW-1:0] pw_addr,
  input  logic [IDXW-1:0] pw_data,
  input  logic [IDXW-1:0] rd_addr,
  output logic [IDXW-1:0] nxt_q,
  output logic [IDXW-1:0] prv_q
);

  logic [IDXW-1:0] mem_next [NODES];
  logic [IDXW-1:0] mem_prev [NODES];

  // Write next links
  always_ff @(posedge clk) begin
    if (nw_en) begin
      mem_next[nw_addr] <= nw_data;
    end
    nxt_q <= mem_next[rd_addr];
  end

  // Write previous links
  always_ff @(posedge clk) begin
    if (pw_en) begin
      mem_prev[pw_addr] <= pw_data;
    end
    prv_q <= mem_prev[rd_addr];
  end

endmodule

FILE: rtl/message_pool_queue_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message_pool_queue_manager
// Pool of message slots kept on circular doubly linked queues, with the
// free list on root 0. Links and slot fields live in on-chip memories.
// ----------------------------------------------------------------------------
// Channel    Direction  Handshake                   Payload
// command    in         start, busy                 func, slot, queue_sel,
//                                                   source_id, event_code,
//                                                   msg_length, dest_id, body_word
// result     out        done (one-cycle strobe)     handle, out_dest, out_source,
//                                                   out_event, out_length, out_body
// config     in/out     psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// Steps: unused codes and ignored commands answer from idle, read passes RDP,
// alloc and receive pass TAKE, TAKE2, UNL, UL1, UL2 (ending at TAKE2 on an
// empty queue), post and free pass UNL, UL1, UL2, AP1, AP2. Init walks the
// link memories one entry a cycle; the steps share one link read address.
// Reset: rst clears control and starts the same link rebuild; busy
// stays high until it ends. A result is shown for one cycle; the receiver
// cannot stall, and a new command is taken as soon as busy is low.
// ----------------------------------------------------------------------------
module message_pool_queue_manager #(
  parameter int NODES      = mpqm_pkg::NODES_DEF,
  parameter int BODY_WIDTH = mpqm_pkg::BODY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            func,
  input  logic [5:0]            slot,
  input  logic [5:0]            queue_sel,
  input  logic [7:0]            source_id,
  input  logic [7:0]            event_code,
  input  logic [7:0]            msg_length,
  input  logic [7:0]            dest_id,
  input  logic [BODY_WIDTH-1:0] body_word,
  output logic                  done,
  output logic [5:0]            handle,
  output logic [7:0]            out_dest,
  output logic [7:0]            out_source,
  output logic [7:0]            out_event,
  output logic [7:0]            out_length,
  output logic [BODY_WIDTH-1:0] out_body,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int IDXW = $clog2(NODES);
  localparam int CW   = mpqm_pkg::CMP_W;
  localparam logic [CW-1:0]   NODES_C = CW'(NODES);
  localparam logic [IDXW-1:0] LAST_IX = IDXW'(NODES - 1);

  // Configuration registers
  logic [5:0] num_roots;
  logic       per_process_mode;

  // Sequencer state
  logic [3:0]      state;
  logic [2:0]      func_r;
  logic [IDXW-1:0] r_q;
  logic [IDXW-1:0] n_q;
  logic            take_q;
  logic            emit_q;
  logic [CW-1:0]   base_q;
  logic [IDXW-1:0] cnt;
  logic [7:0]      src_r;
  logic [7:0]      evt_r;
  logic [7:0]      len_r;

  // Link memory ports
  logic            nw_en;
  logic [IDXW-1:0] nw_addr;
  logic [IDXW-1:0] nw_data;
  logic            pw_en;
  logic [IDXW-1:0] pw_addr;
  logic [IDXW-1:0] pw_data;
  logic [IDXW-1:0] rd_addr;
  logic [IDXW-1:0] nxt_q;
  logic [IDXW-1:0] prv_q;

  // Slot field memories
  logic [23:0]            mem_meta [NODES];
  logic [7:0]             mem_dest [NODES];
  logic [BODY_WIDTH-1:0]  mem_body [NODES];
  logic [23:0]            meta_q;
  logic [7:0]             dest_q;
  logic [BODY_WIDTH-1:0]  body_q;

  // Command decode
  logic            accept;
  logic            wr_cfg;
  logic [CW-1:0]   base_now;
  logic [CW-1:0]   slot_w;
  logic [CW-1:0]   dest_w;
  logic [CW-1:0]   qsel_w;
  logic            slot_ok;
  logic            post_ok;
  logic [IDXW-1:0] slot_ix;
  logic [CW-1:0]   cnt_w;
  logic [CW-1:0]   nr_w;

  assign accept  = start && !busy;
  assign wr_cfg  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign busy    = (state != mpqm_pkg::ST_IDLE);
  assign prdata  = (paddr[2] == mpqm_pkg::REG_MODE) ? {31'd0, per_process_mode}
                                                    : {26'd0, num_roots};
  assign slot_w  = CW'(slot);
  assign dest_w  = CW'(dest_id);
  assign qsel_w  = CW'(queue_sel);
  assign slot_ix = IDXW'(slot);
  assign cnt_w   = CW'(cnt);
  assign nr_w    = CW'(num_roots);
  assign slot_ok = (slot_w >= base_now) && (slot_w < NODES_C);
  assign post_ok = slot_ok && (!per_process_mode || dest_w < base_now);

  // First message slot for the current mode
  always_comb begin
    base_now = mpqm_pkg::MAILBOX_ROOTS;
    if (per_process_mode) begin
      if (nr_w > NODES_C) begin
        base_now = NODES_C;
      end else if (nr_w > mpqm_pkg::MAILBOX_ROOTS) begin
        base_now = nr_w;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_roots        <= 6'd2;
      per_process_mode <= 1'b0;
    end else if (wr_cfg) begin
      if (paddr[2] == mpqm_pkg::REG_MODE) begin
        per_process_mode <= pwdata[0];
      end else begin
        num_roots <= pwdata[5:0];
      end
    end
  end

  // Link memory writes and read address per step
  always_comb begin
    nw_en   = 1'b0;
    nw_addr = n_q;
    nw_data = n_q;
    pw_en   = 1'b0;
    pw_addr = n_q;
    pw_data = n_q;
    rd_addr = n_q;
    case (state)
      mpqm_pkg::ST_TAKE: begin
        rd_addr = r_q;
      end
      mpqm_pkg::ST_UL1: begin
        nw_en   = 1'b1;
        nw_addr = prv_q;
        nw_data = nxt_q;
        pw_en   = 1'b1;
        pw_addr = nxt_q;
        pw_data = prv_q;
      end
      mpqm_pkg::ST_UL2: begin
        nw_en   = 1'b1;
        pw_en   = 1'b1;
        rd_addr = r_q;
      end
      mpqm_pkg::ST_AP1: begin
        nw_en   = 1'b1;
        nw_addr = prv_q;
        pw_en   = 1'b1;
        pw_data = prv_q;
      end
      mpqm_pkg::ST_AP2: begin
        nw_en   = 1'b1;
        nw_data = r_q;
        pw_en   = 1'b1;
        pw_addr = r_q;
      end
      mpqm_pkg::ST_SWEEP: begin
        nw_en   = 1'b1;
        nw_addr = cnt;
        pw_en   = 1'b1;
        pw_addr = cnt;
        if (cnt == '0) begin
          nw_data = (base_q < NODES_C) ? IDXW'(base_q) : '0;
          pw_data = (base_q < NODES_C) ? LAST_IX : '0;
        end else if (cnt_w < base_q) begin
          nw_data = cnt;
          pw_data = cnt;
        end else begin
          nw_data = (cnt == LAST_IX) ? '0 : cnt + 1'b1;
          pw_data = (cnt_w == base_q) ? '0 : cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  mpqm_link_ram #(
    .NODES (NODES),
    .IDXW  (IDXW)
  ) u_link (
    .clk     (clk),
    .nw_en   (nw_en),
    .nw_addr (nw_addr),
    .nw_data (nw_data),
    .pw_en   (pw_en),
    .pw_addr (pw_addr),
    .pw_data (pw_data),
    .rd_addr (rd_addr),
    .nxt_q   (nxt_q),
    .prv_q   (prv_q)
  );

  // Slot fields: post data written at accept, alloc data in the last unlink step
  always_ff @(posedge clk) begin
    if (accept && func == mpqm_pkg::FUNC_POST && post_ok) begin
      mem_dest[slot_ix] <= dest_id;
      mem_body[slot_ix] <= body_word;
    end
    if (state == mpqm_pkg::ST_UL2 && func_r == mpqm_pkg::FUNC_ALLOC) begin
      mem_meta[n_q] <= {src_r, evt_r, len_r};
    end
    meta_q <= mem_meta[slot_ix];
    dest_q <= mem_dest[slot_ix];
    body_q <= mem_body[slot_ix];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= mpqm_pkg::ST_SWEEP;
      cnt    <= '0;
      base_q <= mpqm_pkg::MAILBOX_ROOTS;
      emit_q <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        mpqm_pkg::ST_IDLE: begin
          if (accept) begin
            func_r     <= func;
            src_r      <= source_id;
            evt_r      <= event_code;
            len_r      <= msg_length;
            base_q     <= base_now;
            n_q        <= slot_ix;
            take_q     <= 1'b0;
            handle     <= '0;
            out_dest   <= '0;
            out_source <= '0;
            out_event  <= '0;
            out_length <= '0;
            out_body   <= '0;
            case (func)
              mpqm_pkg::FUNC_INIT: begin
                cnt    <= '0;
                emit_q <= 1'b1;
                state  <= mpqm_pkg::ST_SWEEP;
              end
              mpqm_pkg::FUNC_ALLOC: begin
                r_q    <= IDXW'(mpqm_pkg::FREE_ROOT);
                take_q <= 1'b1;
                state  <= mpqm_pkg::ST_TAKE;
              end
              mpqm_pkg::FUNC_POST: begin
                if (per_process_mode) begin
                  r_q <= IDXW'(dest_id);
                end else begin
                  r_q <= IDXW'(mpqm_pkg::BUSY_ROOT);
                end
                if (post_ok) begin
                  state <= mpqm_pkg::ST_UNL;
                end else begin
                  done <= 1'b1;
                end
              end
              mpqm_pkg::FUNC_RECEIVE: begin
                take_q <= 1'b1;
                if (!per_process_mode) begin
                  r_q   <= IDXW'(mpqm_pkg::BUSY_ROOT);
                  state <= mpqm_pkg::ST_TAKE;
                end else if (qsel_w < base_now) begin
                  r_q   <= IDXW'(queue_sel);
                  state <= mpqm_pkg::ST_TAKE;
                end else begin
                  done <= 1'b1;
                end
              end
              mpqm_pkg::FUNC_FREE: begin
                r_q <= IDXW'(mpqm_pkg::FREE_ROOT);
                if (slot_ok) begin
                  state <= mpqm_pkg::ST_UNL;
                end else begin
                  done <= 1'b1;
                end
              end
              mpqm_pkg::FUNC_READ: begin
                if (slot_w < NODES_C) begin
                  state <= mpqm_pkg::ST_RDP;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        mpqm_pkg::ST_TAKE: begin
          state <= mpqm_pkg::ST_TAKE2;
        end
        // Empty queue gives handle 0
        mpqm_pkg::ST_TAKE2: begin
          if (nxt_q == r_q) begin
            done  <= 1'b1;
            state <= mpqm_pkg::ST_IDLE;
          end else begin
            n_q   <= nxt_q;
            state <= mpqm_pkg::ST_UNL;
          end
        end
        mpqm_pkg::ST_UNL: begin
          state <= mpqm_pkg::ST_UL1;
        end
        mpqm_pkg::ST_UL1: begin
          state <= mpqm_pkg::ST_UL2;
        end
        mpqm_pkg::ST_UL2: begin
          if (take_q) begin
            handle <= 6'(n_q);
            done   <= 1'b1;
            state  <= mpqm_pkg::ST_IDLE;
          end else begin
            state <= mpqm_pkg::ST_AP1;
          end
        end
        mpqm_pkg::ST_AP1: begin
          state <= mpqm_pkg::ST_AP2;
        end
        mpqm_pkg::ST_AP2: begin
          done  <= 1'b1;
          state <= mpqm_pkg::ST_IDLE;
        end
        // Rebuild links one entry a cycle
        mpqm_pkg::ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IX) begin
            done   <= emit_q;
            emit_q <= 1'b0;
            state  <= mpqm_pkg::ST_IDLE;
          end
        end
        mpqm_pkg::ST_RDP: begin
          out_dest   <= dest_q;
          out_source <= meta_q[23:16];
          out_event  <= meta_q[15:8];
          out_length <= meta_q[7:0];
          out_body   <= body_q;
          done       <= 1'b1;
          state      <= mpqm_pkg::ST_IDLE;
        end
        default: begin
          state <= mpqm_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // A result only follows work in progress
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy || accept))
    else $error("result without a command");

  // An accepted command either works or answers next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> (busy || done))
    else $error("command dropped");

  // Sweep index stays inside the pool
  assert property (@(posedge clk) disable iff (rst)
    (state == mpqm_pkg::ST_SWEEP) |-> (cnt_w < NODES_C))
    else $error("sweep index out of range");

  // Only take operations return a nonzero handle
  assert property (@(posedge clk) disable iff (rst) (done && handle != '0) |-> take_q)
    else $error("handle from a non-take operation");

endmodule
